>>> hdl/cbp_pkg.sv
// Shared types, constants and format tables for the coefficient bit packer.
`default_nettype none
package cbp_pkg;

   localparam int unsigned VALUE_W    = 21;
   localparam int unsigned DATA_W     = 24;
   localparam int unsigned ACC_W      = 27;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned FWIDTH_W   = 5;
   localparam int unsigned MAX_RES    = 3;
   localparam int unsigned RES_CNT_W  = 2;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Register index, taken from paddr[2]
   localparam logic REG_FORMAT    = 1'b0;
   localparam logic REG_DIRECTION = 1'b1;

   typedef enum logic [2:0] {
      FMT_ETA2  = 3'd0,
      FMT_ETA4  = 3'd1,
      FMT_T1    = 3'd2,
      FMT_T0    = 3'd3,
      FMT_Z18   = 3'd4,
      FMT_Z20   = 3'd5,
      FMT_W1_6  = 3'd6,
      FMT_W1_4  = 3'd7
   } fmt_type;

   typedef struct packed {
      fmt_type fmt;
      logic    unpack;
      logic    clear;
   } csr_cfg_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]             count;
      logic [MAX_RES-1:0][VALUE_W-1:0]  value;
   } gear_res_type;

   function automatic logic [FWIDTH_W-1:0] fmt_width(input fmt_type f);
      logic [FWIDTH_W-1:0] w;
      case (f)
         FMT_ETA2: w = 5'd3;
         FMT_ETA4: w = 5'd4;
         FMT_T1:   w = 5'd10;
         FMT_T0:   w = 5'd13;
         FMT_Z18:  w = 5'd18;
         FMT_Z20:  w = 5'd20;
         FMT_W1_6: w = 5'd6;
         FMT_W1_4: w = 5'd4;
         default:  w = 5'd3;
      endcase
      return w;
   endfunction

   function automatic logic [VALUE_W-1:0] fmt_offset(input fmt_type f);
      logic [VALUE_W-1:0] o;
      case (f)
         FMT_ETA2: o = 21'd2;
         FMT_ETA4: o = 21'd4;
         FMT_T0:   o = 21'd4096;
         FMT_Z18:  o = 21'd131072;
         FMT_Z20:  o = 21'd524288;
         default:  o = '0;
      endcase
      return o;
   endfunction

   function automatic logic fmt_raw(input fmt_type f);
      logic r;
      case (f)
         FMT_T1, FMT_W1_6, FMT_W1_4: r = 1'b1;
         default:                    r = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/cbp_csr.sv
// APB register file: packing format and direction, with a gearbox clear on write.
`default_nettype none
module cbp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [cbp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [cbp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [cbp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output cbp_pkg::csr_cfg_type                  cfg
);
   import cbp_pkg::*;

   fmt_type fmt_ff;
   logic    unpack_ff;
   logic    wr_en;

   // Word addressed: byte lane bits paddr[1:0] do not take part in the decode
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_ETA2;
         unpack_ff <= 1'b0;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_FORMAT:    fmt_ff    <= fmt_type'(csr_pwdata[2:0]);
            REG_DIRECTION: unpack_ff <= csr_pwdata[0];
            default:       fmt_ff    <= fmt_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FORMAT:    csr_prdata = {{(CSR_DATA_W-3){1'b0}}, fmt_ff};
         REG_DIRECTION: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, unpack_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.fmt    = fmt_ff;
   assign cfg.unpack = unpack_ff;
   assign cfg.clear  = wr_en;

endmodule
`default_nettype wire

>>> hdl/cbp_gearbox.sv
// Gearbox datapath: merges one item into the pending bits and splits off up to three results.
`default_nettype none
module cbp_gearbox (
   input  wire logic [cbp_pkg::VALUE_W-1:0]  in_value,
   input  wire cbp_pkg::csr_cfg_type         cfg,
   input  wire logic [cbp_pkg::ACC_W-1:0]    acc,
   input  wire logic [cbp_pkg::CNT_W-1:0]    bits,
   output cbp_pkg::gear_res_type             res,
   output logic      [cbp_pkg::ACC_W-1:0]    acc_next,
   output logic      [cbp_pkg::CNT_W-1:0]    bits_next
);
   import cbp_pkg::*;

   logic [FWIDTH_W-1:0] w;
   logic [VALUE_W-1:0]  mask;
   logic [VALUE_W-1:0]  offset;
   logic                raw;

   // pack side
   logic [VALUE_W-1:0]  pk_field;
   logic [ACC_W-1:0]    pk_acc;
   logic [CNT_W-1:0]    pk_total;
   logic [1:0]          pk_n;

   // unpack side
   logic [ACC_W-1:0]    up_acc;
   logic [ACC_W-1:0]    up_a1;
   logic [ACC_W-1:0]    up_a2;
   logic [ACC_W-1:0]    up_a3;
   logic [CNT_W:0]      up_total;
   logic [CNT_W:0]      w1;
   logic [CNT_W:0]      w2;
   logic [CNT_W:0]      w3;
   logic [VALUE_W-1:0]  f0;
   logic [VALUE_W-1:0]  f1;
   logic [VALUE_W-1:0]  f2;

   assign w      = fmt_width(cfg.fmt);
   assign offset = fmt_offset(cfg.fmt);
   assign raw    = fmt_raw(cfg.fmt);
   assign mask   = (VALUE_W'(1) << w) - VALUE_W'(1);

   assign pk_field = raw ? (in_value & mask) : ((offset - in_value) & mask);
   assign pk_acc   = acc | (ACC_W'(pk_field) << bits);
   assign pk_total = bits + w;
   assign pk_n     = pk_total[4:3];

   assign up_acc   = acc | (ACC_W'(in_value[7:0]) << bits);
   assign up_total = {1'b0, bits} + (CNT_W+1)'(8);
   assign w1       = {1'b0, w};
   assign w2       = {w, 1'b0};
   assign w3       = w1 + w2;
   assign up_a1    = up_acc >> w;
   assign up_a2    = up_a1 >> w;
   assign up_a3    = up_a2 >> w;
   assign f0       = up_acc[VALUE_W-1:0] & mask;
   assign f1       = up_a1[VALUE_W-1:0] & mask;
   assign f2       = up_a2[VALUE_W-1:0] & mask;

   always_comb begin
      res.count = '0;
      res.value = '0;
      acc_next  = acc;
      bits_next = bits;
      if (!cfg.unpack) begin
         res.count    = pk_n;
         res.value[0] = VALUE_W'(pk_acc[7:0]);
         res.value[1] = VALUE_W'(pk_acc[15:8]);
         res.value[2] = VALUE_W'(pk_acc[23:16]);
         acc_next     = pk_acc >> {pk_n, 3'b000};
         bits_next    = pk_total - {pk_n, 3'b000};
      end else begin
         res.value[0] = raw ? f0 : (offset - f0);
         res.value[1] = raw ? f1 : (offset - f1);
         res.value[2] = raw ? f2 : (offset - f2);
         if (up_total >= w3) begin
            res.count = 2'd3;
            acc_next  = up_a3;
            bits_next = CNT_W'(up_total - w3);
         end else if (up_total >= w2) begin
            res.count = 2'd2;
            acc_next  = up_a2;
            bits_next = CNT_W'(up_total - w2);
         end else if (up_total >= w1) begin
            res.count = 2'd1;
            acc_next  = up_a1;
            bits_next = CNT_W'(up_total - w1);
         end else begin
            res.count = 2'd0;
            acc_next  = up_acc;
            bits_next = CNT_W'(up_total);
         end
      end
   end

endmodule
`default_nettype wire

>>> hdl/cbp_result_buf.sv
// Result register for one item's results, delivered one per cycle unless stalled.
`default_nettype none
module cbp_result_buf (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire cbp_pkg::gear_res_type         load_res,
   output logic                               can_load,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [cbp_pkg::DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import cbp_pkg::*;

   logic [RES_CNT_W-1:0]            count_ff;
   logic [MAX_RES-1:0][VALUE_W-1:0] value_ff;
   logic                            pop;

   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (count_ff == '0) || (count_ff == RES_CNT_W'(1) && rsp_tready);
   assign rsp_tdata  = {{(DATA_W-VALUE_W){1'b0}}, value_ff[0]};
   assign rsp_tlast  = (count_ff == RES_CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= load_res.count;
      end else if (pop) begin
         count_ff <= count_ff - RES_CNT_W'(1);
      end
   end

   // Advance the queue toward entry zero on each delivered item
   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= load_res.value;
      end else if (pop) begin
         value_ff[0] <= value_ff[1];
         value_ff[1] <= value_ff[2];
      end
   end

endmodule
`default_nettype wire

>>> hdl/coefficient_bit_packer.sv
// Coefficient bit packer top level: input register, gearbox state and result register.
`default_nettype none
// Packs signed polynomial coefficients into bytes, LSB first, or unpacks bytes
// into coefficients, in the format chosen by the format register (eta2, eta4,
// t1, t0, z18, z20, w1 six-bit, w1 four-bit). An item is held in the input
// register, its results are formed in one pass and land in the result
// register, from which the result port delivers them. An item releases from
// zero to three results: the result port delivers one result per cycle while
// the receiver takes them, and the next item moves on once the last result of
// the one before is being taken. Items that release nothing pass at one per
// cycle. Writing either register drops any pending partial bits; the user must
// write the registers only while the block is idle, which the block itself
// does not enforce.
module coefficient_bit_packer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: [20:0] in_value (signed), [23:21] zero
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [cbp_pkg::DATA_W-1:0]       req_tdata,
   // rsp_tdata: [20:0] out_value (signed), [23:21] zero
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [cbp_pkg::DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [cbp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [cbp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [cbp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import cbp_pkg::*;

   csr_cfg_type         cfg;
   gear_res_type        gear_res;
   logic                in_valid_ff;
   logic [VALUE_W-1:0]  in_value_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [CNT_W-1:0]    bits_ff;
   logic [CNT_W-1:0]    bits_in;
   logic                buf_can_load;
   logic                consume;
   logic                load;

   cbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbp_gearbox u_gearbox (
      .in_value  (in_value_ff),
      .cfg       (cfg),
      .acc       (acc_ff),
      .bits      (bits_ff),
      .res       (gear_res),
      .acc_next  (acc_in),
      .bits_next (bits_in)
   );

   cbp_result_buf u_result_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_res   (gear_res),
      .can_load   (buf_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // An item with no result only updates the gearbox, so it never waits
   assign consume    = in_valid_ff && (gear_res.count == '0 || buf_can_load);
   assign load       = consume && (gear_res.count != '0);
   assign req_tready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_value_ff <= req_tdata[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         acc_ff  <= '0;
         bits_ff <= '0;
      end else if (consume) begin
         acc_ff  <= acc_in;
         bits_ff <= bits_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/cbp_checker.sv
// Port-level checks for the coefficient bit packer, bound to the top level.
`default_nettype none
module cbp_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [cbp_pkg::DATA_W-1:0]       rsp_tdata,
   input  wire logic                             rsp_tlast
);
   import cbp_pkg::*;

   // Reset drops any queued result
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With the result side empty, the input side must be open
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while no result is pending");

   // Padding above the value never carries data
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DATA_W-1:VALUE_W] == '0))
      else $error("result padding bits set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind coefficient_bit_packer cbp_checker u_cbp_checker (.*);
`default_nettype wire
